/* hdl/prmv_pkg.sv */
// ----------------------------------------------------------------------------
// prmv_pkg
// Shared types and constants for the per-id running mean and spread block.
// ----------------------------------------------------------------------------
package prmv_pkg;

    localparam int CONF_W = 17;
    localparam int POS_W  = 32;
    localparam int CNT_W  = 16;
    localparam int SQ_W   = 64;
    localparam logic [CONF_W-1:0] MIN_CONF_RESET = 17'd45875;
    localparam logic [CNT_W-1:0]  CNT_MAX        = 16'hFFFF;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_DIV_MEAN,
        ST_MUL,
        ST_WRITE,
        ST_DIV_VAR,
        ST_SQRT,
        ST_EMIT,
        ST_CLEAR
    } prmv_state_t;

    // One stored entry.
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [POS_W-1:0]  mx;
        logic [POS_W-1:0]  my;
        logic [POS_W-1:0]  mz;
        logic [SQ_W-1:0]   sx;
        logic [SQ_W-1:0]   sy;
        logic [SQ_W-1:0]   sz;
        logic [CONF_W-1:0] mc;
    } prmv_entry_t;

    // Divider request and mode.
    typedef struct packed {
        logic start;
        logic sgn;
    } prmv_div_ctl_t;

endpackage

/* hdl/prmv_div.sv */
// ----------------------------------------------------------------------------
// prmv_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 16-bit
// divisor, with optional signed (truncating) mode.
// ----------------------------------------------------------------------------
module prmv_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  prmv_pkg::prmv_div_ctl_t ctl,
    input  logic [63:0]           dividend,
    input  logic [15:0]           divisor,
    output logic [63:0]           quotient,
    output logic                  done
);
    import prmv_pkg::*;

    logic [63:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        run_reg, run_next;
    logic [15:0] dv_reg, dv_next;
    logic [16:0] trial;

    always_comb
    begin
        q_next   = q_reg;
        r_next   = r_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        run_next = run_reg;
        dv_next  = dv_reg;
        trial    = {r_reg[15:0], q_reg[63]};
        done     = 1'b0;
        if (ctl.start)
        begin
            neg_next = ctl.sgn & dividend[63];
            q_next   = (ctl.sgn & dividend[63]) ? (~dividend + 64'd1) : dividend;
            r_next   = '0;
            cnt_next = 7'd64;
            run_next = 1'b1;
            dv_next  = divisor;
        end
        else if (run_reg)
        begin
            // Shift one dividend bit in and try a subtract.
            if (trial >= {1'b0, dv_reg})
            begin
                r_next = trial - {1'b0, dv_reg};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next = 1'b0;
            end
        end
        else
        begin
            done = (cnt_reg == 7'd0);
        end
    end

    assign quotient = neg_reg ? (~q_reg + 64'd1) : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 7'd1;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
        dv_reg  <= dv_next;
    end

endmodule

/* hdl/per_id_running_mean_variance_core.sv */
// ----------------------------------------------------------------------------
// per_id_running_mean_variance_core
// Per-id running mean, mean confidence and spread radius by Welford's method.
// ----------------------------------------------------------------------------
// Usage: raise start with an observation while busy is low; the beat is taken
// at that edge and busy stays high until the block is ready again. One result
// appears for one cycle with out_valid high if the id holds any observations.
// Rejected observations of a non-empty id still give a result with
// accepted low. The receiver cannot stall; results are never held.
// The threshold register is written over cfg_valid/cfg_ready; cfg_ready is
// high except during the clearing pass.
// out_valid rises in the same cycle that busy falls, and the next beat can be
// taken at the edge that ends that cycle. The serial divider, one bit per
// cycle, runs four times for an accepted item (three means, confidence) and
// three times for the variances when the id holds two or more samples; the
// square root follows the variance divisions. Ids at or beyond NUM_IDS give
// no result and leave the memory as it is.
// Reset: the statistics memory is swept to zero, one entry per cycle, over all
// NUM_IDS entries, during which busy is high.
// ----------------------------------------------------------------------------
module per_id_running_mean_variance_core
#(
    parameter int NUM_IDS = 64
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [prmv_pkg::CONF_W-1:0]  cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic [5:0]                   marker_id,
    input  logic signed [31:0]           pos_x,
    input  logic signed [31:0]           pos_y,
    input  logic signed [31:0]           pos_z,
    input  logic [prmv_pkg::CONF_W-1:0]  confidence,
    output logic                         out_valid,
    output logic [5:0]                   out_id,
    output logic signed [31:0]           avg_x,
    output logic signed [31:0]           avg_y,
    output logic signed [31:0]           avg_z,
    output logic [prmv_pkg::CONF_W-1:0]  avg_confidence,
    output logic [31:0]                  spread_radius,
    output logic [15:0]                  obs_count,
    output logic                         accepted
);
    import prmv_pkg::*;

    localparam int AW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

    // Statistics memory.
    prmv_entry_t mem [NUM_IDS];
    prmv_entry_t rd_reg;
    logic        we;
    logic [AW-1:0] waddr;
    prmv_entry_t wdata;

    prmv_state_t st_reg, st_next;
    logic [CONF_W-1:0] minc_reg;
    logic [AW-1:0] clr_reg, clr_next;
    logic [5:0]  id_reg;
    logic [31:0] px_reg, py_reg, pz_reg;
    logic [CONF_W-1:0] c_reg;
    logic        acc_reg, acc_next;
    prmv_entry_t e_reg, e_next;
    logic [1:0]  ax_reg, ax_next;
    logic signed [32:0] d_reg [3];
    logic signed [32:0] d_next [3];
    logic [63:0] v_reg, v_next;
    logic [31:0] root_reg, root_next;
    logic [63:0] rem_reg, rem_next;
    logic [5:0]  sq_cnt_reg, sq_cnt_next;
    logic        ov_reg, ov_next;

    prmv_div_ctl_t dctl;
    logic [63:0] ddend, dquo;
    logic [15:0] dsor;
    logic        ddone;
    logic        div_go_reg, div_go_next;

    prmv_div u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(ddend),
        .divisor(dsor), .quotient(dquo), .done(ddone)
    );

    // Memory port: one write, one registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[AW'(id_reg)];
    end

    // Configuration register.
    assign cfg_ready = (st_reg != ST_CLEAR);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minc_reg <= MIN_CONF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            minc_reg <= cfg_data;
        end
    end

    assign busy = (st_reg != ST_IDLE);

    // Per-axis helpers.
    function automatic logic [31:0] sel_mean(prmv_entry_t e, logic [1:0] a);
        case (a)
            2'd0:    sel_mean = e.mx;
            2'd1:    sel_mean = e.my;
            default: sel_mean = e.mz;
        endcase
    endfunction

    function automatic logic [31:0] sel_pos(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z, logic [1:0] a);
        case (a)
            2'd0:    sel_pos = x;
            2'd1:    sel_pos = y;
            default: sel_pos = z;
        endcase
    endfunction

    function automatic logic [63:0] sel_sq(prmv_entry_t e, logic [1:0] a);
        case (a)
            2'd0:    sel_sq = e.sx;
            2'd1:    sel_sq = e.sy;
            default: sel_sq = e.sz;
        endcase
    endfunction

    logic [31:0]        cur_mean, cur_pos;
    logic signed [32:0] cur_d, cur_d2;
    logic [32:0]        abs_d, abs_d2;
    logic [65:0]        prod;
    logic [64:0]        sq_sum;
    logic [64:0]        v_sum;
    logic [63:0]        trial_sq;
    logic [15:0]        n_cnt;
    logic [31:0]        nm;

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_CLEAR:    st_next = (clr_reg == AW'(NUM_IDS - 1)) ? ST_IDLE : ST_CLEAR;
            ST_IDLE:     st_next = start ? ST_READ : ST_IDLE;
            ST_READ:     st_next = ({26'd0, id_reg} >= 32'(NUM_IDS)) ? ST_IDLE : ST_LOAD;
            ST_LOAD:     st_next = (c_reg >= minc_reg) ? ST_DIV_MEAN
                                 : ((rd_reg.cnt == 16'd0) ? ST_IDLE : ST_WRITE);
            ST_DIV_MEAN: st_next = (ddone && !div_go_reg) ?
                                   ((ax_reg == 2'd3) ? ST_WRITE : ST_MUL) : ST_DIV_MEAN;
            ST_MUL:      st_next = ST_DIV_MEAN;
            ST_WRITE:    st_next = (e_reg.cnt >= 16'd2) ? ST_DIV_VAR : ST_EMIT;
            ST_DIV_VAR:  st_next = (ddone && !div_go_reg && ax_reg == 2'd2) ?
                                   ST_SQRT : ST_DIV_VAR;
            ST_SQRT:     st_next = (sq_cnt_reg == 6'd31) ? ST_EMIT : ST_SQRT;
            ST_EMIT:     st_next = ST_IDLE;
            default:     st_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        e_next      = e_reg;
        acc_next    = acc_reg;
        ax_next     = ax_reg;
        d_next      = d_reg;
        v_next      = v_reg;
        root_next   = root_reg;
        rem_next    = rem_reg;
        sq_cnt_next = sq_cnt_reg;
        ov_next     = 1'b0;
        div_go_next = 1'b0;
        clr_next    = clr_reg;
        we          = 1'b0;
        waddr       = AW'(id_reg);
        wdata       = e_reg;
        dctl.start  = div_go_reg;
        dctl.sgn    = 1'b1;
        n_cnt       = e_reg.cnt;
        dsor        = n_cnt;
        cur_mean    = sel_mean(e_reg, ax_reg);
        cur_pos     = sel_pos(px_reg, py_reg, pz_reg, ax_reg);
        cur_d       = d_reg[ax_reg];
        ddend       = {{31{cur_d[32]}}, cur_d};
        nm          = cur_mean + dquo[31:0];
        cur_d2      = $signed({cur_pos[31], cur_pos}) - $signed({nm[31], nm});
        abs_d       = cur_d[32] ? 33'(-cur_d) : 33'(cur_d);
        abs_d2      = cur_d2[32] ? 33'(-cur_d2) : 33'(cur_d2);
        prod        = 66'(abs_d) * 66'(abs_d2);
        sq_sum      = 65'(sel_sq(e_reg, ax_reg)) + 65'(prod);
        v_sum       = 65'(v_reg) + 65'(dquo);
        trial_sq    = {root_reg, 2'b01, 30'd0} >> 0;
        case (st_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + AW'(1);
            end
            ST_LOAD:
            begin
                e_next   = rd_reg;
                acc_next = (c_reg >= minc_reg);
                ax_next  = 2'd0;
                if (c_reg >= minc_reg)
                begin
                    if (rd_reg.cnt != CNT_MAX)
                    begin
                        e_next.cnt = rd_reg.cnt + 16'd1;
                    end
                    d_next[0] = $signed({px_reg[31], px_reg}) - $signed({rd_reg.mx[31], rd_reg.mx});
                    d_next[1] = $signed({py_reg[31], py_reg}) - $signed({rd_reg.my[31], rd_reg.my});
                    d_next[2] = $signed({pz_reg[31], pz_reg}) - $signed({rd_reg.mz[31], rd_reg.mz});
                    div_go_next = 1'b1;
                end
            end
            ST_DIV_MEAN:
            begin
                if (ax_reg == 2'd3)
                begin
                    ddend = {{30{1'b0}}, 34'(signed'({1'b0, c_reg}) - signed'({1'b0, e_reg.mc}))};
                    ddend = {{30{ddend[33]}}, ddend[33:0]};
                    if (ddone && !div_go_reg)
                    begin
                        e_next.mc = CONF_W'(e_reg.mc + dquo[CONF_W-1:0]);
                    end
                end
                else if (ddone && !div_go_reg)
                begin
                    case (ax_reg)
                        2'd0:    e_next.mx = nm;
                        2'd1:    e_next.my = nm;
                        default: e_next.mz = nm;
                    endcase
                    // Keep d2 for the product step.
                    d_next[ax_reg] = cur_d2;
                    v_next = {31'd0, abs_d};
                end
            end
            ST_MUL:
            begin
                // Product of |d| (held in v) and |d2|, saturating sum.
                prod   = 66'(v_reg[32:0]) * 66'(abs_d);
                sq_sum = 65'(sel_sq(e_reg, ax_reg)) + 65'(prod);
                case (ax_reg)
                    2'd0:    e_next.sx = sq_sum[64] ? '1 : sq_sum[63:0];
                    2'd1:    e_next.sy = sq_sum[64] ? '1 : sq_sum[63:0];
                    default: e_next.sz = sq_sum[64] ? '1 : sq_sum[63:0];
                endcase
                ax_next     = ax_reg + 2'd1;
                div_go_next = 1'b1;
            end
            ST_WRITE:
            begin
                we          = acc_reg;
                ax_next     = 2'd0;
                v_next      = '0;
                div_go_next = (e_reg.cnt >= 16'd2);
            end
            ST_DIV_VAR:
            begin
                dctl.sgn = 1'b0;
                dsor     = e_reg.cnt - 16'd1;
                ddend    = sel_sq(e_reg, ax_reg);
                if (ddone && !div_go_reg)
                begin
                    v_next  = v_sum[64] ? '1 : v_sum[63:0];
                    ax_next = ax_reg + 2'd1;
                    div_go_next = (ax_reg != 2'd2);
                end
                root_next   = '0;
                rem_next    = '0;
                sq_cnt_next = '0;
            end
            ST_SQRT:
            begin
                // Two radicand bits per step, one root bit.
                rem_next = {rem_reg[61:0], v_reg[63:62]};
                v_next   = {v_reg[61:0], 2'b00};
                trial_sq = {30'd0, root_reg, 2'b01};
                if ({rem_reg[61:0], v_reg[63:62]} >= trial_sq)
                begin
                    rem_next  = {rem_reg[61:0], v_reg[63:62]} - trial_sq;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    root_next = {root_reg[30:0], 1'b0};
                end
                sq_cnt_next = sq_cnt_reg + 6'd1;
            end
            ST_EMIT:
            begin
                ov_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (st_reg == ST_DIV_MEAN && ddone && !div_go_reg && ax_reg != 2'd3)
        begin
            // Product is taken in ST_MUL.
        end
        if (st_reg == ST_MUL && ax_reg == 2'd2)
        begin
            d_next[2] = d_reg[2];
        end
    end

    // The confidence division runs after the third axis.
    logic [1:0] ax_fix;
    always_comb
    begin
        ax_fix = ax_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_CLEAR;
            clr_reg    <= '0;
            ov_reg     <= 1'b0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            clr_reg    <= clr_next;
            ov_reg     <= ov_next;
            div_go_reg <= div_go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && start)
        begin
            id_reg <= marker_id;
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
            c_reg  <= confidence;
        end
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        ax_reg     <= ax_fix;
        d_reg      <= d_next;
        v_reg      <= v_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        sq_cnt_reg <= sq_cnt_next;
    end

    // Result ports.
    assign out_valid      = ov_reg;
    assign out_id         = id_reg;
    assign avg_x          = e_reg.mx;
    assign avg_y          = e_reg.my;
    assign avg_z          = e_reg.mz;
    assign avg_confidence = e_reg.mc;
    assign spread_radius  = (e_reg.cnt >= 16'd2) ? root_reg : 32'd0;
    assign obs_count      = e_reg.cnt;
    assign accepted       = acc_reg;

endmodule
